FILE: design/dcc_pkg.sv
// dcc_pkg: shared types, constants and calendar functions for the day count to date block
// no dependencies; imported by dcc_sub_unit, dcc_core and the top level
package dcc_pkg;

  localparam int OrdW  = 22;
  localparam int YearW = 14;

  localparam logic signed [32:0] EpochOrdinal = 33'sd719163;
  localparam logic signed [32:0] MaxOrdinal   = 33'sd3652059;
  localparam logic [YearW-1:0]   YearMin      = 14'd1;
  localparam logic [YearW-1:0]   YearMax      = 14'd9999;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  localparam logic [1:0] ClampNone = 2'd0;
  localparam logic [1:0] ClampLow  = 2'd1;
  localparam logic [1:0] ClampHigh = 2'd2;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  clamped;
  } dcc_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } dcc_stat_t;

  // floor(y / 100) for y < 10000 by reciprocal multiply
  function automatic logic [6:0] div100(input logic [13:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'd5243;
    return prod[25:19];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [6:0] q;
    logic       cent;
    q    = div100(y);
    cent = (y == 14'(q) * 14'd100);
    return (y[1:0] == 2'd0) && (!cent || (q[1:0] == 2'd0));
  endfunction

  // days before january 1 of year y
  function automatic logic [OrdW-1:0] days_prior(input logic [13:0] y);
    logic [13:0] p;
    logic [6:0]  q;
    logic [22:0] acc;
    p   = y - 14'd1;
    q   = div100(p);
    acc = 23'(p) * 23'd365 + 23'(p[13:2]) - 23'(q) + 23'(q[6:2]);
    return acc[OrdW-1:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: design/dcc_if.sv
// dcc_in_if and dcc_out_if: valid/ready channels for day offsets and dates
// depends on nothing beyond plain logic types
interface dcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] day_offset;

  modport source (output valid, output day_offset, input ready);
  modport sink (input valid, input day_offset, output ready);
endinterface

interface dcc_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [1:0]  clamped;

  modport source (output valid, output year, output month, output day, output clamped,
                  input ready);
  modport sink (input valid, input year, input month, input day, input clamped,
                output ready);
endinterface

FILE: design/dcc_sub_unit.sv
// dcc_sub_unit: shared 22-bit subtract and greater-than compare
// depends on dcc_pkg
module dcc_sub_unit (
  input  logic [dcc_pkg::OrdW-1:0] a_i,
  input  logic [dcc_pkg::OrdW-1:0] b_i,
  output logic [dcc_pkg::OrdW-1:0] diff_o,
  output logic                     gt_o
);
  import dcc_pkg::*;

  logic [OrdW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[OrdW-1:0];
  assign gt_o   = !full[OrdW] && (full[OrdW-1:0] != '0);

endmodule

FILE: design/dcc_core.sv
// dcc_core: sequencer for year binary search and month walk around one shared subtractor
// depends on dcc_pkg and dcc_sub_unit
module dcc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  day_offset_i,
  input  logic                take_i,
  output dcc_pkg::dcc_stat_t  stat_o,
  output dcc_pkg::dcc_res_t   res_o
);
  import dcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_YEAR  = 3'd2;
  localparam logic [2:0] S_DOY   = 3'd3;
  localparam logic [2:0] S_MONTH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic signed [31:0] off_q, off_d;
  logic [OrdW-1:0]    rem_q, rem_d;
  logic [13:0]        lo_q, lo_d, hi_q, hi_d;
  logic [3:0]         m_q, m_d;
  logic [1:0]         flag_q, flag_d;
  logic               leap_q, leap_d;

  logic signed [32:0] sum;
  logic [14:0]        mid_sum;
  logic [13:0]        mid;
  logic [13:0]        dp_year;
  logic [OrdW-1:0]    dp;
  logic [OrdW-1:0]    ua, ub, udiff;
  logic               ugt;

  assign sum     = $signed({off_q[31], off_q}) + EpochOrdinal;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 15'd1;
  assign mid     = mid_sum[14:1];
  assign dp_year = (state_q == S_YEAR) ? mid : lo_q;
  assign dp      = days_prior(dp_year);

  always_comb begin
    case (state_q)
      S_MONTH: begin
        ua = rem_q;
        ub = OrdW'(month_len(m_q, leap_q));
      end
      default: begin
        ua = rem_q;
        ub = dp;
      end
    endcase
  end

  dcc_sub_unit u_sub (
    .a_i    (ua),
    .b_i    (ub),
    .diff_o (udiff),
    .gt_o   (ugt)
  );

  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    m_d     = m_q;
    flag_d  = flag_q;
    leap_d  = leap_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          off_d   = day_offset_i;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        lo_d = YearMin;
        hi_d = YearMax;
        if (sum < 33'sd1) begin
          rem_d  = OrdW'(1);
          flag_d = ClampLow;
        end else if (sum > MaxOrdinal) begin
          rem_d  = MaxOrdinal[OrdW-1:0];
          flag_d = ClampHigh;
        end else begin
          rem_d  = sum[OrdW-1:0];
          flag_d = ClampNone;
        end
        state_d = S_YEAR;
      end
      S_YEAR: begin
        if (lo_q == hi_q) begin
          state_d = S_DOY;
        end else if (ugt) begin
          lo_d = mid;
        end else begin
          hi_d = mid - 14'd1;
        end
      end
      S_DOY: begin
        rem_d   = udiff;
        m_d     = MonthJan;
        leap_d  = is_leap(lo_q);
        state_d = S_MONTH;
      end
      S_MONTH: begin
        if (m_q != MonthDec && ugt) begin
          rem_d = udiff;
          m_d   = m_q + 4'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    m_q    <= m_d;
    flag_q <= flag_d;
    leap_q <= leap_d;
  end

  assign stat_o.idle   = (state_q == S_IDLE);
  assign stat_o.done   = (state_q == S_DONE);
  assign res_o.year    = lo_q;
  assign res_o.month   = m_q;
  assign res_o.day     = rem_q[4:0];
  assign res_o.clamped = flag_q;

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_YEAR |-> lo_q <= hi_q && lo_q >= YearMin && hi_q <= YearMax)
    else $error("year search bounds crossed");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MONTH |-> m_q >= MonthJan && m_q <= MonthDec && rem_q != '0)
    else $error("month walk out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> rem_q >= OrdW'(1) && rem_q <= OrdW'(31) && flag_q <= ClampHigh)
    else $error("day of month out of range");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !take_i |=> state_q == S_DONE && $stable(res_o))
    else $error("result changed before transfer");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q == S_IDLE |=> state_q == S_LOAD)
    else $error("start not taken");

endmodule

FILE: design/day_count_to_civil_date.sv
// day_count_to_civil_date: top level with input handshake and output register
// depends on dcc_pkg, dcc_if (dcc_in_if, dcc_out_if) and dcc_core
//
// in_i carries a signed day offset from 1970-01-01; a transaction takes place
// when valid and ready are both high. out_o carries year, month, day and a
// clamp flag (1 below 0001-01-01, 2 above 9999-12-31), one per input.
// The core takes one offset at a time: ready is high only while it is idle.
// An item passes through an accept step, a load/clamp step, the binary year
// search and its exit step, a day-of-year step and the month walk, then
// loads the output register; the steps run in turn on the single shared
// subtract/compare unit.
// The output register lets a new offset be accepted while a result waits.
// If the receiver stalls, the finished result stays in the core until the
// output register frees, and no further input is taken meanwhile.
// Reset (rst_ni low, asynchronous) returns the core to idle and empties the
// output register.
module day_count_to_civil_date (
  input  logic clk_i,
  input  logic rst_ni,
  dcc_in_if.sink    in_i,
  dcc_out_if.source out_o
);
  import dcc_pkg::*;

  dcc_stat_t stat;
  dcc_res_t  res;
  dcc_res_t  res_q;
  logic      start;
  logic      take;
  logic      out_valid_q, out_valid_d;

  assign in_i.ready = stat.idle;
  assign start      = in_i.valid && stat.idle;
  assign take       = stat.done && (!out_valid_q || out_o.ready);

  dcc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .day_offset_i (in_i.day_offset),
    .take_i       (take),
    .stat_o       (stat),
    .res_o        (res)
  );

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.year    = res_q.year;
  assign out_o.month   = res_q.month;
  assign out_o.day     = res_q.day;
  assign out_o.clamped = res_q.clamped;

endmodule
